>>> design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types and constants for the ARP responder and its cache cells.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	localparam int CACHE_ENTRIES = 16;

	localparam logic [10:0] MIN_ARP_LEN = 11'd28;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;
	localparam logic [15:0] OP_REPLY    = 16'h0002;

	localparam int CFG_W = 48;

	typedef enum logic {
		CFG_OWN_IP  = 1'b0,
		CFG_OWN_MAC = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		OUT_IGNORED = 3'd0,
		OUT_REPLY   = 3'd1,
		OUT_NOT_US  = 3'd2,
		OUT_CACHED  = 3'd3,
		OUT_FULL    = 3'd4,
		OUT_HIT     = 3'd5,
		OUT_MISS    = 3'd6
	} outcome_t;

	typedef struct packed {
		logic        action;
		logic [10:0] packet_length;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [47:0] eth_src_mac;
		logic [31:0] lookup_ip;
	} in_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [47:0] reply_dest_mac;
		logic [31:0] reply_target_ip;
		logic [47:0] found_mac;
	} out_t;

	// Token that walks the cell chain. For a store it carries the MAC to
	// write; for a lookup it collects the MAC of the matching slot.
	typedef struct packed {
		logic        valid;
		logic        store;
		logic        hit;
		logic [31:0] ip;
		logic [47:0] mac;
	} tok_t;

endpackage

`default_nettype wire

>>> design/arpc_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// One cache slot. Serves a passing token (store or lookup) and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_cell import arpc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic [31:0] ip_q;
	logic [47:0] mac_q;
	tok_t        tok_q;
	tok_t        tok_next;
	logic        take;

	// Only the first matching slot along the chain serves a token.
	always_comb begin
		tok_next = tok_in;
		take     = 1'b0;
		if (tok_in.valid && !tok_in.hit) begin
			if (tok_in.store) begin
				if (ip_q == 32'd0) begin
					take         = 1'b1;
					tok_next.hit = 1'b1;
				end
			end else if (ip_q == tok_in.ip) begin
				tok_next.hit = 1'b1;
				tok_next.mac = mac_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q  <= '0;
			mac_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
			if (take) begin
				ip_q  <= tok_in.ip;
				mac_q <= tok_in.mac;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

>>> design/arp_responder_with_cache.sv
// A request or an ignored packet gives its result beat the cycle after
// acceptance; a cache store or lookup passes the launch register, then walks
// CACHE_ENTRIES cells, one cell per cycle, before its result is registered.
// Throughput: one item at a time; the next item is taken the cycle after the
// result beat leaves. Reset clears the control state, our IP address and every
// cache slot at once.
// ----------------------------------------------------------------------------
// ARP responder with cache
// Answers ARP requests for our IP, caches ARP replies and serves lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder_with_cache import arpc_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  wire              out_stall,
	output out_t             out_data,
	input  wire              cfg_we,
	input  cfg_index_t       cfg_index,
	input  wire  [CFG_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] own_ip_q;
	tok_t        launch_q;
	out_t        out_q;
	tok_t        chain [CACHE_ENTRIES+1];
	tok_t        tail;
	logic        accept;
	tok_t        launch_d;
	out_t        idle_out;

	assign chain[0] = launch_q;
	assign tail     = chain[CACHE_ENTRIES];

	genvar gi;
	generate
		for (gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cell
			arpc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.tok_in  (chain[gi]),
				.tok_out (chain[gi+1])
			);
		end
	endgenerate

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = out_q;

	// Lookups and replies go down the cell chain; everything else is answered
	// straight away.
	always_comb begin
		launch_d = '0;
		idle_out = '{OUT_IGNORED, 48'd0, 32'd0, 48'd0};
		if (accept) begin
			if (in_data.action) begin
				launch_d = '{1'b1, 1'b0, 1'b0, in_data.lookup_ip, 48'd0};
			end else if (in_data.packet_length >= MIN_ARP_LEN &&
					in_data.opcode == OP_REPLY) begin
				launch_d = '{1'b1, 1'b1, 1'b0, in_data.sender_ip, in_data.sender_mac};
			end else if (in_data.packet_length >= MIN_ARP_LEN &&
					in_data.opcode == OP_REQUEST) begin
				if (in_data.target_ip == own_ip_q) begin
					idle_out = '{OUT_REPLY, in_data.eth_src_mac, in_data.sender_ip, 48'd0};
				end else begin
					idle_out.outcome = OUT_NOT_US;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			own_ip_q <= '0;
			launch_q <= '0;
			out_q    <= '0;
		end else begin
			// Our MAC only goes into the sender field of the outgoing frame,
			// which is built downstream, so it is not held here.
			if (cfg_we && cfg_index == CFG_OWN_IP) begin
				own_ip_q <= cfg_data[31:0];
			end
			launch_q <= launch_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_q   <= idle_out;
						state_q <= launch_d.valid ? ST_BUSY : ST_OUT;
					end
				end
				ST_BUSY: begin
					if (tail.valid) begin
						if (tail.store) begin
							out_q <= '{tail.hit ? OUT_CACHED : OUT_FULL, 48'd0, 32'd0, 48'd0};
						end else if (tail.hit) begin
							out_q <= '{OUT_HIT, 48'd0, 32'd0, tail.mac};
						end else begin
							out_q <= '{OUT_MISS, 48'd0, 32'd0, 48'd0};
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP responder checker
// Port-level assertions on the ARP responder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_checker import arpc_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              in_valid,
	input wire              in_stall,
	input wire              out_valid,
	input wire              out_stall,
	input out_t             out_data
);

	// One item in flight: nothing is taken while a result beat waits.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result beat is pending");

	// An accepted beat closes the input until its result has left.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (in_stall && !(out_valid && !out_stall &&
			$past(out_valid))))
		else $error("input not held off after an accepted beat");

	// Reply fields are zero unless a reply is to be sent.
	a_reply_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.outcome != OUT_REPLY) |->
			(out_data.reply_dest_mac == 48'd0 && out_data.reply_target_ip == 32'd0))
		else $error("reply fields set on a non-reply result");

	// A found MAC only comes with a hit.
	a_found_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.outcome != OUT_HIT) |-> (out_data.found_mac == 48'd0))
		else $error("found MAC set on a result that is not a hit");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result beat changed");

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
